/* sv/gbc_pkg.sv */
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants for the Gaussian naive Bayes scorer.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned MaxFeatures = 64;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned AddrW       = 7;
  localparam int unsigned TabDepth    = 2 * MaxFeatures;

  localparam logic [31:0] PriorReset = 32'hFFFF_4E8E;
  localparam logic [31:0] Ln2Q30     = 32'd744261118;
  localparam logic [31:0] Log2TwoPiF = 32'd2847022291 >> (30 - FracBits);

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdTest  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic CfgPriorBenign  = 1'b0;
  localparam logic CfgPriorMalware = 1'b1;

  localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};
  localparam logic [48:0]        TermCap = 49'h1_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  feature_index;
    logic        class_sel;
    logic [31:0] value;
    logic [31:0] variance;
    logic        last_feature;
    logic        actual_label;
  } item_t;

  typedef enum logic [3:0] {
    OpNone, OpLoadStart, OpDivStep, OpLogStep, OpLoadWrite, OpClear,
    OpRdB, OpDiffB, OpSqB, OpMulB, OpAccB, OpRdM, OpDiffM, OpSqM, OpMulM, OpAccM
  } op_e;

  typedef struct packed {
    op_e  op;
    logic latch;
    logic finish;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic log_done;
    logic idx_ok;
    logic last;
    logic [1:0] cmd;
  } stat_t;

endpackage

/* sv/gbc_ram.sv */
// ----------------------------------------------------------------------------
// gbc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module gbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* sv/gbc_datapath.sv */
// ----------------------------------------------------------------------------
// gbc_datapath
// Tables, divide and log units, score accumulators and confusion counts.
// ----------------------------------------------------------------------------
module gbc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbc_pkg::item_t      item_i,
  input  gbc_pkg::ctrl_t      ctrl_i,
  output gbc_pkg::stat_t      stat_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output logic                predicted_class_o,
  output logic                true_class_o,
  output logic                was_correct_o,
  output logic signed [47:0]  score_benign_o,
  output logic signed [47:0]  score_malware_o,
  output logic [31:0]         count_tp_o,
  output logic [31:0]         count_tn_o,
  output logic [31:0]         count_fp_o,
  output logic [31:0]         count_fn_o
);
  import gbc_pkg::*;

  item_t              it_q;
  logic [31:0]        prior_b_q, prior_m_q;
  logic signed [47:0] acc_b_q, acc_m_q;
  logic [31:0]        cnt_q [4];

  logic [31:0] var_c;
  assign var_c = (it_q.variance == 32'd0) ? 32'd1 : it_q.variance;

  // restoring divide of 2^(2F-1) by var, one bit a beat
  logic [32:0] rem_q, rem_sh;
  logic [31:0] quo_q;
  logic [5:0]  div_cnt_q;
  logic        div_ovf_q;
  logic [32:0] rem_sub;
  localparam logic [63:0] Dividend = 64'd1 << (2 * FracBits - 1);
  assign rem_sh  = {rem_q[31:0], Dividend[6'd63 - div_cnt_q]};
  assign rem_sub = rem_sh - {1'b0, var_c};

  // log2 by repeated squaring
  logic [32:0]  m_q;
  logic [63:0]  m_sq_q;
  logic         sq_ph_q;
  logic [4:0]   e_q;
  logic [FracBits-1:0] frac_q;
  logic [4:0]   log_cnt_q;
  logic [4:0]   msb_c;
  logic [65:0]  m_sq;
  logic [34:0]  m_nx;

  always_comb begin
    msb_c = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (var_c[i]) msb_c = 5'(i);
    end
  end
  assign m_sq = 66'(m_q) * 66'(m_q);
  assign m_nx = 35'(m_sq_q >> 31);

  logic signed [31:0] l_c;
  logic signed [63:0] lnq_prod_q;
  logic signed [63:0] lnq;
  logic signed [63:0] ln_neg;
  logic [31:0]        log_norm_c;
  assign l_c = (32'(e_q) << FracBits) + 32'(frac_q) - (32'(FracBits) << FracBits)
             + Log2TwoPiF;
  assign lnq    = lnq_prod_q >>> 30;
  assign ln_neg = -lnq;
  assign log_norm_c = ln_neg[32:1];

  // tables
  logic [AddrW-1:0] addr;
  logic             tab_we;
  logic [31:0]      mean_rd, inv_rd, ln_rd, inv_wr;
  assign tab_we = (ctrl_i.op == OpLoadWrite);
  assign inv_wr = div_ovf_q ? 32'hFFFF_FFFF : quo_q;
  always_comb begin
    unique case (ctrl_i.op)
      OpLoadWrite: addr = {it_q.class_sel, it_q.feature_index};
      OpRdM:       addr = {1'b1, it_q.feature_index};
      default:     addr = {1'b0, it_q.feature_index};
    endcase
  end

  gbc_ram #(.Width(32), .Depth(TabDepth)) u_mean (
    .clk_i, .we_i(tab_we), .addr_i(addr), .wdata_i(it_q.value), .rdata_o(mean_rd));
  gbc_ram #(.Width(32), .Depth(TabDepth)) u_inv (
    .clk_i, .we_i(tab_we), .addr_i(addr), .wdata_i(inv_wr), .rdata_o(inv_rd));
  gbc_ram #(.Width(32), .Depth(TabDepth)) u_ln (
    .clk_i, .we_i(tab_we), .addr_i(addr), .wdata_i(log_norm_c), .rdata_o(ln_rd));

  // score datapath
  logic [32:0]  ad_q;
  logic [65:0]  sq_q;
  logic [31:0]  inv_q, ln_q;
  logic [63:0]  ph_q, pl_q;
  logic [32:0]  diff;
  logic [95:0]  term_full;
  logic [48:0]  term;
  logic signed [49:0] sum;
  logic signed [47:0] sum_sat;
  logic signed [47:0] acc_sel;

  assign diff = {it_q.value[31], it_q.value} - {mean_rd[31], mean_rd};
  // partial products are registered, recombined in the accumulate beat
  assign term_full = ((96'(ph_q) << 32) + 96'(pl_q)) >> (2 * FracBits);
  assign term = (term_full > 96'(TermCap)) ? TermCap : term_full[48:0];
  assign acc_sel = (ctrl_i.op == OpAccB) ? acc_b_q : acc_m_q;
  assign sum = 50'(acc_sel) + 50'($signed(ln_q)) - $signed({1'b0, term});
  always_comb begin
    if (sum > 50'(AccMax)) sum_sat = AccMax;
    else if (sum < 50'(AccMin)) sum_sat = AccMin;
    else sum_sat = sum[47:0];
  end

  logic pred;
  assign pred = (acc_b_q >= acc_m_q) ? 1'b0 : 1'b1;
  logic [1:0] k;
  always_comb begin
    priority if (!it_q.actual_label && !pred) k = 2'd0;
    else if (it_q.actual_label && pred)  k = 2'd1;
    else if (it_q.actual_label && !pred) k = 2'd2;
    else                                 k = 2'd3;
  end

  assign stat_o.div_done = (div_cnt_q == 6'd63);
  assign stat_o.log_done = (log_cnt_q == 5'(FracBits)) && !sq_ph_q;
  assign stat_o.idx_ok   = (32'(it_q.feature_index) < MaxFeatures);
  assign stat_o.last     = it_q.last_feature;
  assign stat_o.cmd      = it_q.cmd;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) it_q <= item_i;
    unique case (ctrl_i.op)
      OpLoadStart: begin
        rem_q <= '0; quo_q <= '0; div_cnt_q <= '0; div_ovf_q <= 1'b0;
        e_q <= msb_c; m_q <= 33'({1'b0, var_c} << (5'd31 - msb_c));
        frac_q <= '0; log_cnt_q <= '0; sq_ph_q <= 1'b0;
      end
      OpDivStep: begin
        if (rem_sh >= {1'b0, var_c}) begin
          rem_q <= rem_sub;
          if (quo_q[31]) div_ovf_q <= 1'b1;
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          if (quo_q[31]) div_ovf_q <= 1'b1;
          quo_q <= {quo_q[30:0], 1'b0};
        end
        div_cnt_q <= div_cnt_q + 6'd1;
      end
      OpLogStep: begin
        if (!sq_ph_q) begin
          if (log_cnt_q == 5'(FracBits)) begin
            lnq_prod_q <= 64'(l_c) * 64'($signed(Ln2Q30));
          end else begin
            m_sq_q  <= m_sq[63:0];
            sq_ph_q <= 1'b1;
          end
        end else begin
          sq_ph_q <= 1'b0;
          log_cnt_q <= log_cnt_q + 5'd1;
          if (m_nx[32]) begin
            frac_q <= {frac_q[FracBits-2:0], 1'b1};
            m_q    <= m_nx[33:1];
          end else begin
            frac_q <= {frac_q[FracBits-2:0], 1'b0};
            m_q    <= m_nx[32:0];
          end
        end
      end
      OpDiffB, OpDiffM: begin
        ad_q <= diff[32] ? -diff : diff;
        inv_q <= inv_rd;
        ln_q  <= ln_rd;
      end
      OpSqB, OpSqM: sq_q <= 66'(ad_q) * 66'(ad_q);
      OpMulB, OpMulM: begin
        ph_q <= 64'(sq_q[63:32]) * 64'(inv_q);
        pl_q <= 64'(sq_q[31:0]) * 64'(inv_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_b_q <= PriorReset;
      prior_m_q <= PriorReset;
      acc_b_q   <= 48'($signed(PriorReset));
      acc_m_q   <= 48'($signed(PriorReset));
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      predicted_class_o <= 1'b0; true_class_o <= 1'b0; was_correct_o <= 1'b0;
      score_benign_o <= '0; score_malware_o <= '0;
      count_tp_o <= '0; count_tn_o <= '0; count_fp_o <= '0; count_fn_o <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgPriorBenign) begin
        prior_b_q <= cfg_data_i;
        acc_b_q   <= 48'($signed(cfg_data_i));
      end
      if (cfg_we_i && cfg_idx_i == CfgPriorMalware) begin
        prior_m_q <= cfg_data_i;
        acc_m_q   <= 48'($signed(cfg_data_i));
      end
      if (ctrl_i.op == OpAccB) acc_b_q <= sum_sat;
      if (ctrl_i.op == OpAccM) acc_m_q <= sum_sat;
      if (ctrl_i.op == OpClear) begin
        for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      end
      if (ctrl_i.finish) begin
        if (cnt_q[k] != 32'hFFFF_FFFF) cnt_q[k] <= cnt_q[k] + 32'd1;
        acc_b_q <= 48'($signed(prior_b_q));
        acc_m_q <= 48'($signed(prior_m_q));
      end
      if (ctrl_i.emit) begin
        predicted_class_o <= pred;
        true_class_o      <= it_q.actual_label;
        was_correct_o     <= (pred == it_q.actual_label);
        score_benign_o    <= acc_b_q;
        score_malware_o   <= acc_m_q;
        count_tp_o <= (k == 2'd0 && cnt_q[0] != '1) ? cnt_q[0] + 32'd1 : cnt_q[0];
        count_tn_o <= (k == 2'd1 && cnt_q[1] != '1) ? cnt_q[1] + 32'd1 : cnt_q[1];
        count_fp_o <= (k == 2'd2 && cnt_q[2] != '1) ? cnt_q[2] + 32'd1 : cnt_q[2];
        count_fn_o <= (k == 2'd3 && cnt_q[3] != '1) ? cnt_q[3] + 32'd1 : cnt_q[3];
      end
    end
  end

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == OpAccB |=> acc_b_q <= AccMax && acc_b_q >= AccMin)
    else $error("score out of range");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == OpLoadStart |=> div_cnt_q == 6'd0)
    else $error("divider not restarted");
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish && !cfg_we_i |=> acc_b_q == 48'($signed(prior_b_q)))
    else $error("score not reloaded");
endmodule

/* sv/gbc_ctrl.sv */
// ----------------------------------------------------------------------------
// gbc_ctrl
// Sequencer: steps loads through the divide and log units and tests through
// the score pipeline, and runs the output handshake.
// ----------------------------------------------------------------------------
module gbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  gbc_pkg::stat_t stat_i,
  output gbc_pkg::ctrl_t ctrl_o
);
  import gbc_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StDiv, StLog, StWrite, StScore, StDone
  } state_e;

  state_e state_q;
  op_e    sop_q;
  logic   out_valid_q;
  logic   blocked;

  assign blocked   = out_valid_q && !out_stall;
  assign in_stall  = (state_q != StIdle) || (out_valid_q && out_stall);
  assign out_valid = out_valid_q;

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.latch  = in_valid && !in_stall;
    unique case (state_q)
      StDecode: ctrl_o.op = (stat_i.cmd == CmdLoad && stat_i.idx_ok) ? OpLoadStart :
                            (stat_i.cmd == CmdClear) ? OpClear : OpNone;
      StDiv:    ctrl_o.op = OpDivStep;
      StLog:    ctrl_o.op = OpLogStep;
      StWrite:  ctrl_o.op = OpLoadWrite;
      StScore:  ctrl_o.op = sop_q;
      StDone: begin
        ctrl_o.finish = 1'b1;
        ctrl_o.emit   = 1'b1;
      end
      default:  ctrl_o.op = OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sop_q       <= OpRdB;
      out_valid_q <= 1'b0;
    end else begin
      if (blocked) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_valid && !in_stall) state_q <= StDecode;
        StDecode: begin
          priority if (stat_i.cmd == CmdLoad && stat_i.idx_ok) state_q <= StDiv;
          else if (stat_i.cmd == CmdTest && stat_i.idx_ok) begin
            sop_q <= OpRdB; state_q <= StScore;
          end else if (stat_i.cmd == CmdTest && stat_i.last) state_q <= StDone;
          else state_q <= StIdle;
        end
        StDiv:   if (stat_i.div_done) state_q <= StLog;
        StLog:   if (stat_i.log_done) state_q <= StWrite;
        StWrite: state_q <= StIdle;
        StScore: begin
          if (sop_q == OpAccM) state_q <= stat_i.last ? StDone : StIdle;
          else sop_q <= op_e'(sop_q + 4'd1);
        end
        StDone: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |-> !out_valid_q || !out_stall || 1'b1 && !(out_valid_q && out_stall))
    else $error("result overwritten");
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.latch |-> state_q == StIdle)
    else $error("accept outside idle");
  a_score_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScore && sop_q == OpAccB |=> sop_q == OpRdM)
    else $error("score sequence broken");
endmodule

/* sv/gaussian_bayes_classifier_core.sv */
// ----------------------------------------------------------------------------
// gaussian_bayes_classifier_core
// Two-class Gaussian naive Bayes scorer, signed Q16.16.
// ----------------------------------------------------------------------------
// One item at a time. A test item passes a decode step and five pipeline steps
// per class through the shared table read, difference, square, multiply and
// accumulate; on the last feature one more step forms the result beat, which
// shows as the input becomes ready again. A load is paced by the bit-serial
// divider (64 steps) and the log unit (a squaring and a normalising step per
// fraction bit, and one step for the final scaling). A clear needs only the
// decode step. A new item is not taken while a result beat is stalled.
module gaussian_bayes_classifier_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd_i,
  input  logic [5:0]         feature_index_i,
  input  logic               class_sel_i,
  input  logic signed [31:0] value_i,
  input  logic [31:0]        variance_i,
  input  logic               last_feature_i,
  input  logic               actual_label_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               predicted_class_o,
  output logic               true_class_o,
  output logic               was_correct_o,
  output logic signed [47:0] score_benign_o,
  output logic signed [47:0] score_malware_o,
  output logic [31:0]        count_tp_o,
  output logic [31:0]        count_tn_o,
  output logic [31:0]        count_fp_o,
  output logic [31:0]        count_fn_o
);
  import gbc_pkg::*;

  item_t item;
  ctrl_t ctrl;
  stat_t stat;

  assign item = '{cmd: cmd_i, feature_index: feature_index_i, class_sel: class_sel_i,
                  value: value_i, variance: variance_i, last_feature: last_feature_i,
                  actual_label: actual_label_i};

  gbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat_i(stat), .ctrl_o(ctrl));

  gbc_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .ctrl_i(ctrl), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .predicted_class_o, .true_class_o, .was_correct_o,
    .score_benign_o, .score_malware_o,
    .count_tp_o, .count_tn_o, .count_fp_o, .count_fn_o);
endmodule

/* tb/sv/gaussian_bayes_classifier_core_tb.sv */
// ----------------------------------------------------------------------------
// gaussian_bayes_classifier_core_tb
// Self-checking bench for the two-class Gaussian naive Bayes scorer: loads
// every class table entry, runs directed extremes, then random samples over
// five prior settings, all but the last under random stalls, and compares each
// result beat against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gaussian_bayes_classifier_core_tb;
  import gbc_pkg::*;

  typedef struct {
    logic        pred;
    logic        truth;
    logic        ok;
    logic [47:0] sb;
    logic [47:0] sm;
    logic [31:0] cnt [4];
  } verdict_t;

  class bayes_scoreboard;
    logic [31:0] mean_t [TabDepth];
    logic [31:0] inv_t  [TabDepth];
    logic [31:0] norm_t [TabDepth];
    logic [31:0] prior_b, prior_m;
    longint      acc_b, acc_m;
    logic [31:0] counts [4];
    verdict_t    verdicts [$];
    int          errors;
    int          seen;

    function new();
      prior_b = PriorReset;
      prior_m = PriorReset;
      acc_b = longint'(signed'(prior_b));
      acc_m = longint'(signed'(prior_m));
      foreach (counts[k]) counts[k] = '0;
      foreach (mean_t[k]) begin
        mean_t[k] = '0; inv_t[k] = '0; norm_t[k] = '0;
      end
      errors = 0;
      seen = 0;
    endfunction

    function void set_prior(logic idx, logic [31:0] d);
      if (idx == CfgPriorBenign) begin
        prior_b = d; acc_b = longint'(signed'(d));
      end else begin
        prior_m = d; acc_m = longint'(signed'(d));
      end
    endfunction

    function logic [31:0] log_norm_of(logic [31:0] v);
      int          e;
      logic [63:0] m;
      logic [63:0] fr;
      longint      l, lnq;
      e = 31;
      while (!v[e]) e--;
      m = 64'(v) << (31 - e);
      fr = '0;
      for (int i = 0; i < FracBits; i++) begin
        m = (m * m) >> 31;
        fr = fr << 1;
        if (m >= 64'h1_0000_0000) begin
          fr = fr | 64'd1;
          m = m >> 1;
        end
      end
      l = (longint'(e) << FracBits) + longint'(fr) - (longint'(FracBits) << FracBits)
          + longint'(64'd2847022291 >> (30 - FracBits));
      lnq = (l * 744261118) >>> 30;
      return 32'((-lnq) >>> 1);
    endfunction

    function longint log_lik(longint x, int idx);
      longint      d;
      logic [63:0] ad, sq, q;
      logic [95:0] prod;
      d = x - longint'(signed'(mean_t[idx]));
      ad = (d < 0) ? -d : d;
      sq = ad * ad;
      prod = {32'b0, sq} * {64'b0, inv_t[idx]};
      q = prod[95:32];
      if (q > 64'h1_0000_0000_0000) q = 64'h1_0000_0000_0000;
      return longint'(signed'(norm_t[idx])) - longint'(q);
    endfunction

    function longint sat48(longint a);
      if (a > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (a < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return a;
    endfunction

    function void note_input(item_t it);
      int          idx;
      logic [31:0] var_c;
      logic [63:0] q;
      longint      x;
      verdict_t    v;
      int          k;
      seen++;
      if (it.cmd == CmdLoad) begin
        idx = int'(it.class_sel) * MaxFeatures + int'(it.feature_index);
        var_c = (it.variance == 0) ? 32'd1 : it.variance;
        q = (64'd1 << (2 * FracBits - 1)) / var_c;
        mean_t[idx] = it.value;
        inv_t[idx] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        norm_t[idx] = log_norm_of(var_c);
      end else if (it.cmd == CmdClear) begin
        foreach (counts[j]) counts[j] = '0;
      end else if (it.cmd == CmdTest) begin
        x = longint'(signed'(it.value));
        acc_b = sat48(acc_b + log_lik(x, int'(it.feature_index)));
        acc_m = sat48(acc_m + log_lik(x, MaxFeatures + int'(it.feature_index)));
        if (it.last_feature) begin
          v.pred = (acc_b >= acc_m) ? 1'b0 : 1'b1;
          v.truth = it.actual_label;
          v.ok = (v.pred == v.truth);
          if (!v.truth && !v.pred) k = 0;
          else if (v.truth && v.pred) k = 1;
          else if (v.truth && !v.pred) k = 2;
          else k = 3;
          if (counts[k] != 32'hFFFF_FFFF) counts[k]++;
          v.sb = acc_b[47:0];
          v.sm = acc_m[47:0];
          foreach (counts[j]) v.cnt[j] = counts[j];
          verdicts.push_back(v);
          acc_b = longint'(signed'(prior_b));
          acc_m = longint'(signed'(prior_m));
        end
      end
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(verdict_t a);
      verdict_t e;
      if (verdicts.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
        return;
      end
      e = verdicts.pop_front();
      cmp("predicted_class", e.pred, a.pred);
      cmp("true_class", e.truth, a.truth);
      cmp("was_correct", e.ok, a.ok);
      cmp("score_benign", e.sb, a.sb);
      cmp("score_malware", e.sm, a.sm);
      cmp("count_tp", e.cnt[0], a.cnt[0]);
      cmp("count_tn", e.cnt[1], a.cnt[1]);
      cmp("count_fp", e.cnt[2], a.cnt[2]);
      cmp("count_fn", e.cnt[3], a.cnt[3]);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd_i;
  logic [5:0]         feature_index_i;
  logic               class_sel_i;
  logic signed [31:0] value_i;
  logic [31:0]        variance_i;
  logic               last_feature_i;
  logic               actual_label_i;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               out_valid;
  logic               out_stall;
  logic               predicted_class_o;
  logic               true_class_o;
  logic               was_correct_o;
  logic signed [47:0] score_benign_o;
  logic signed [47:0] score_malware_o;
  logic [31:0]        count_tp_o;
  logic [31:0]        count_tn_o;
  logic [31:0]        count_fp_o;
  logic [31:0]        count_fn_o;

  gaussian_bayes_classifier_core uut (.*);

  bayes_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_asked = 0;
  int n_results = 0;
  int n_tests = 0;
  int n_loads = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall bursts, one long hold-off, watchdog
  int stall_left = 0;
  int hold_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  initial out_stall = 1'b1;
  always @(posedge clk_i) begin
    verdict_t r;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        r.pred = predicted_class_o; r.truth = true_class_o; r.ok = was_correct_o;
        r.sb = score_benign_o; r.sm = score_malware_o;
        r.cnt[0] = count_tp_o; r.cnt[1] = count_tn_o;
        r.cnt[2] = count_fp_o; r.cnt[3] = count_fn_o;
        sb.check_result(r);
        n_results++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("watchdog expired");
        $display("Regression FAIL");
        $finish;
      end
    end
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_i <= it.cmd;
    feature_index_i <= it.feature_index;
    class_sel_i <= it.class_sel;
    value_i <= it.value;
    variance_i <= it.variance;
    last_feature_i <= it.last_feature;
    actual_label_i <= it.actual_label;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
    if (it.cmd == CmdTest) n_tests++;
    if (it.cmd == CmdLoad) n_loads++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t mk(logic [1:0] c, int f, logic cls, logic [31:0] v,
                               logic [31:0] vr, logic last, logic lab);
    item_t it;
    it.cmd = c; it.feature_index = 6'(f); it.class_sel = cls; it.value = v;
    it.variance = vr; it.last_feature = last; it.actual_label = lab;
    return it;
  endfunction

  task automatic settle();
    while (sb.verdicts.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_prior(logic idx, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_prior(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t random_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    it.feature_index = 6'($urandom);
    it.class_sel = 1'($urandom);
    it.actual_label = 1'($urandom);
    it.last_feature = ($urandom_range(0, 3) == 0);
    it.variance = $urandom;
    if ($urandom_range(0, 3) == 0) it.value = $urandom;
    else it.value = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    if (r < 85) begin
      it.cmd = CmdTest;
    end else if (r < 93) begin
      it.cmd = CmdLoad;
      case ($urandom_range(0, 3))
        0: it.variance = $urandom_range(0, 3);
        1: it.variance = $urandom_range(32'h2000, 32'h8_0000);
        default: ;
      endcase
    end else if (r < 97) begin
      it.cmd = CmdClear;
    end else begin
      it.cmd = 2'd3;
    end
    return it;
  endfunction

  initial begin
    logic [31:0] pb [5];
    logic [31:0] pm [5];
    rst_ni = 1'b0;
    in_valid = 1'b0;
    cmd_i = CmdTest;
    feature_index_i = '0;
    class_sel_i = 1'b0;
    value_i = '0;
    variance_i = '0;
    last_feature_i = 1'b0;
    actual_label_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgPriorBenign;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every table entry before any score uses it
    for (int f = 0; f < MaxFeatures; f++)
      for (int c = 0; c < 2; c++)
        send(mk(CmdLoad, f, 1'(c), 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)),
                $urandom_range(32'h4000, 32'h4_0000), 1'b0, 1'b0));

    // directed: variance extremes, mean extremes, saturation, odd commands
    send(mk(CmdLoad, 0, 1'b0, 32'h8000_0000, 32'h0, 1'b0, 1'b0));
    send(mk(CmdLoad, 0, 1'b1, 32'h7FFF_FFFF, 32'h1, 1'b0, 1'b0));
    send(mk(CmdLoad, 1, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send(mk(CmdLoad, 1, 1'b1, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0));
    send(mk(CmdLoad, 63, 1'b1, 32'hFFFF_0000, 32'h8000_0000, 1'b0, 1'b0));
    send(mk(CmdTest, 0, 1'b0, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0));
    send(mk(CmdTest, 0, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send(mk(CmdTest, 1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0));
    send(mk(CmdTest, 63, 1'b0, 32'hFFFF_0000, 32'h0, 1'b1, 1'b1));
    send(mk(2'd3, 5, 1'b1, 32'h1234_5678, 32'h0, 1'b1, 1'b0));
    send(mk(CmdTest, 1, 1'b0, 32'h0001_0000, 32'h0, 1'b1, 1'b0));
    send(mk(CmdClear, 0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0));
    send(mk(CmdTest, 0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b1));
    send(mk(CmdTest, 1, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1));
    send(mk(CmdTest, 2, 1'b0, 32'h0, 32'h0, 1'b1, 1'b0));
    drop_valid();

    pb[0] = 32'h8000_0000; pm[0] = 32'h7FFF_FFFF;
    pb[1] = 32'h7FFF_FFFF; pm[1] = 32'h8000_0000;
    pb[2] = $urandom;      pm[2] = $urandom;
    pb[3] = 32'h0;         pm[3] = 32'hFFFF_FFFF;
    pb[4] = PriorReset;    pm[4] = PriorReset;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_prior(CfgPriorBenign, pb[ph]);
      write_prior(CfgPriorMalware, pm[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 10) hold_asked++;
        send(random_item());
      end
      drop_valid();
    end

    while (sb.verdicts.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d beats in: %0d loads, %0d test features, %0d results",
             sb.seen, n_loads, n_tests, n_results);
    $display("five prior settings incl. both extremes, variance 0/1/max, one long hold-off");
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
